/* rtl/core/bdh_pkg.sv */
// Shared types and constants of the button debounce and hold detector.
`default_nettype none
package bdh_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned FLAG_W   = 2;
    localparam int unsigned STATE_W  = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [STATE_W-1:0] ST_RELEASED      = 3'd0;
    localparam logic [STATE_W-1:0] ST_CHK_PRESS     = 3'd1;
    localparam logic [STATE_W-1:0] ST_PRESSED       = 3'd2;
    localparam logic [STATE_W-1:0] ST_CHK_REL_PRESS = 3'd3;
    localparam logic [STATE_W-1:0] ST_HELD          = 3'd4;
    localparam logic [STATE_W-1:0] ST_CHK_REL_HOLD  = 3'd5;

    localparam logic [FLAG_W-1:0] FLAG_IDLE    = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_PRESSED = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_RELEASE = 2'd2;
    localparam logic [FLAG_W-1:0] FLAG_HELD    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'd1;

    localparam logic [THR_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [THR_W-1:0] HOLD_RST     = 16'd500;

    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0] debounce_ms;
        logic [THR_W-1:0] hold_ms;
    } t_cfg;

endpackage
`default_nettype wire

/* rtl/core/bdh_cfg.sv */
// Configuration registers: debounce and hold thresholds.
`default_nettype none
module bdh_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [bdh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bdh_pkg::THR_W-1:0]      i_cfg_data,
    output bdh_pkg::t_cfg                       o_cfg
);

    bdh_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= bdh_pkg::DEBOUNCE_RST;
            r_cfg.hold_ms     <= bdh_pkg::HOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bdh_pkg::CFG_DEBOUNCE: r_cfg.debounce_ms <= i_cfg_data;
                bdh_pkg::CFG_HOLD:     r_cfg.hold_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* rtl/core/bdh_fsm.sv */
// Debounce and hold state machine with its timestamps.
`default_nettype none
module bdh_fsm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic                          i_level,
    input  wire logic [bdh_pkg::TIME_W-1:0]    i_now,
    input  bdh_pkg::t_cfg                      i_cfg,
    output logic      [bdh_pkg::FLAG_W-1:0]    o_flag
);

    logic [bdh_pkg::STATE_W-1:0] r_state, n_state;
    logic [bdh_pkg::TIME_W-1:0]  r_change, n_change;
    logic [bdh_pkg::TIME_W-1:0]  r_press, n_press;
    logic [bdh_pkg::TIME_W-1:0]  since_change, since_press;
    logic                        deb_met, hold_met;

    assign since_change = i_now - r_change;
    assign since_press  = i_now - r_press;
    assign deb_met  = since_change >= {{(bdh_pkg::TIME_W-bdh_pkg::THR_W){1'b0}}, i_cfg.debounce_ms};
    assign hold_met = since_press  >= {{(bdh_pkg::TIME_W-bdh_pkg::THR_W){1'b0}}, i_cfg.hold_ms};

    always_comb begin
        n_state  = r_state;
        n_change = r_change;
        n_press  = r_press;
        o_flag   = bdh_pkg::FLAG_IDLE;
        case (r_state)
            bdh_pkg::ST_CHK_PRESS: begin
                if (i_level == bdh_pkg::PIN_RELEASED) begin
                    n_state = bdh_pkg::ST_RELEASED;
                end else if (deb_met) begin
                    n_state = bdh_pkg::ST_PRESSED;
                    n_press = i_now;
                end
            end
            bdh_pkg::ST_PRESSED: begin
                o_flag = bdh_pkg::FLAG_PRESSED;
                if (i_level == bdh_pkg::PIN_RELEASED) begin
                    n_state  = bdh_pkg::ST_CHK_REL_PRESS;
                    n_change = i_now;
                end else if (hold_met) begin
                    n_state = bdh_pkg::ST_HELD;
                end
            end
            bdh_pkg::ST_CHK_REL_PRESS: begin
                o_flag = bdh_pkg::FLAG_RELEASE;
                if (i_level == bdh_pkg::PIN_PRESSED) begin
                    n_state = bdh_pkg::ST_PRESSED;
                    n_press = i_now;
                end else if (deb_met) begin
                    n_state = bdh_pkg::ST_RELEASED;
                end
            end
            bdh_pkg::ST_HELD: begin
                o_flag = bdh_pkg::FLAG_HELD;
                if (i_level == bdh_pkg::PIN_RELEASED) begin
                    n_state  = bdh_pkg::ST_CHK_REL_HOLD;
                    n_change = i_now;
                end
            end
            bdh_pkg::ST_CHK_REL_HOLD: begin
                if (i_level == bdh_pkg::PIN_PRESSED) begin
                    n_state = bdh_pkg::ST_HELD;
                end else if (deb_met) begin
                    n_state = bdh_pkg::ST_RELEASED;
                end
            end
            default: begin
                n_state = bdh_pkg::ST_RELEASED;
                if (i_level == bdh_pkg::PIN_PRESSED) begin
                    n_state  = bdh_pkg::ST_CHK_PRESS;
                    n_change = i_now;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bdh_pkg::ST_RELEASED;
            r_change <= '0;
            r_press  <= '0;
        end else if (i_advance) begin
            r_state  <= n_state;
            r_change <= n_change;
            r_press  <= n_press;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/bdh_out.sv */
// Result register holding one flag item for the downstream side.
`default_nettype none
module bdh_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic [bdh_pkg::FLAG_W-1:0]  i_flag,
    input  wire logic                        i_stall,
    output logic                             o_free,
    output logic                             o_valid,
    output logic      [bdh_pkg::FLAG_W-1:0]  o_flag
);

    logic                        r_valid;
    logic [bdh_pkg::FLAG_W-1:0]  r_flag;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_flag <= i_flag;
        end
    end

    assign o_valid = r_valid;
    assign o_flag  = r_flag;

endmodule
`default_nettype wire

/* rtl/core/button_debounce_hold_detector.sv */
// Top level of the button debounce and hold detector.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one sample item per cycle,
//   while not stalled: the active-low pin level and a free-running millisecond time.
//   Output channel (o_out_valid / i_out_stall) returns one press_flag item per
//   sample: 0 idle, 1 pressed, 2 release from pressed being confirmed, 3 held. The flag
//   reflects the debounce state before that sample.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   index 0 debounce_ms and index 1 hold_ms; write only while idle.
// Flow: an accepted item enters the input register, and its flag is loaded into
//   the result register once that register is free. Throughput: one item per cycle
//   while unstalled, set by the single state update between the two registers.
// Reset: synchronous, active low; state returns to released, timestamps to
//   zero, thresholds to 20 ms and 500 ms, both registers empty.
// Stall: while the result register is full and stalled, the input register
//   holds its item and o_in_stall rises once it is occupied; no item is lost.
`default_nettype none
module button_debounce_hold_detector (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_button_level,
    input  wire logic [bdh_pkg::TIME_W-1:0]     i_now_ms,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [bdh_pkg::FLAG_W-1:0]     o_press_flag,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bdh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bdh_pkg::THR_W-1:0]      i_cfg_data
);

    bdh_pkg::t_cfg               cfg;
    logic                        r_in_vld;
    logic                        r_level;
    logic [bdh_pkg::TIME_W-1:0]  r_now;
    logic                        out_free;
    logic                        advance;
    logic                        in_acc;
    logic [bdh_pkg::FLAG_W-1:0]  flag;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_vld && out_free;
    assign o_in_stall  = r_in_vld && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || out_free) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_level <= i_button_level;
            r_now   <= i_now_ms;
        end
    end

    bdh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bdh_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_level   (r_level),
        .i_now     (r_now),
        .i_cfg     (cfg),
        .o_flag    (flag)
    );

    bdh_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_flag  (flag),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_flag  (o_press_flag)
    );

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced item did not reach result register");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_hold_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_free) |=> (r_in_vld && $stable(r_now) && $stable(r_level)))
        else $error("input register changed while blocked");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_in_vld)
        else $error("accepted item missing from input register");

endmodule
`default_nettype wire
